// ----- hw/rtl/msam_pkg.sv -----
// ----------------------------------------------------------------------------
// msam_pkg
// Shared types and constants of the multi-stream audio mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package msam_pkg;

  localparam int unsigned SourceSlots  = 8;
  localparam int unsigned FifoSamples  = 64;
  localparam int unsigned ExcludeSlots = 8;
  localparam int unsigned SlotW  = $clog2(SourceSlots);
  localparam int unsigned PtrW   = $clog2(FifoSamples);
  localparam int unsigned CntW   = PtrW + 1;
  localparam int unsigned ExclW  = $clog2(ExcludeSlots);
  localparam int unsigned SumW   = 19;
  localparam int unsigned OneQ15 = 32768;

  localparam logic [2:0] ReqPush      = 3'd0;
  localparam logic [2:0] ReqMix       = 3'd1;
  localparam logic [2:0] ReqExclude   = 3'd2;
  localparam logic [2:0] ReqClrExcl   = 3'd3;
  localparam logic [2:0] ReqClrAll    = 3'd4;

  localparam logic [1:0] KindAck      = 2'd0;
  localparam logic [1:0] KindSample   = 2'd1;
  localparam logic [1:0] KindNone     = 2'd2;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatDropped  = 2'd1;
  localparam logic [1:0] StatFull     = 2'd2;

  localparam logic [1:0] AddrChannels = 2'd0;
  localparam logic [1:0] AddrCap      = 2'd1;

  typedef enum logic [3:0] {
    StIdle,
    StPush,
    StPushWr,
    StExcl,
    StScan,
    StSumClr,
    StSumRd,
    StSumAcc,
    StPeak,
    StDiv,
    StEmit,
    StConsume,
    StAck
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/multi_stream_audio_mixer.sv -----
// ----------------------------------------------------------------------------
// multi_stream_audio_mixer
// Per-source audio FIFOs with a normalizing mixer, one request at a time.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis group (tuser = request kind, tlast = end of a
// push call, tdata = {sample, process id}); results leave on m_axis. An APB
// port holds channel_count (0x0) and cap_frames (0x4).
// A push, an exclude, a clear or an unknown request is answered with one
// acknowledge; source and exclusion tables are searched one entry a cycle
// through a single pid comparator.
// A mix walks the slot table twice (with the exclusion lookup shared), clears
// the sums, reads each contributing FIFO sample by sample through one adder
// into the sum memory, finds the peak in one pass, and for every output
// sample runs a 34-step restoring divider when the peak exceeds 1.0, else
// passes the sum through; with nothing to mix the answer is a none result.
// tready is low while a request is in work. A result waits in the output
// register while the receiver stalls, and the sequencer holds until it goes.
// Reset clears all slot and exclusion valid bits and sets the registers to
// 2 channels and 32 frames; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_stream_audio_mixer import msam_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // process_id, sample
  input  wire logic [2:0]  s_axis_tuser,  // req_type
  input  wire logic        s_axis_tlast,  // push_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // mixed_sample, frames_mixed, sample_index
  output logic [3:0]       m_axis_tuser,  // result_kind, status
  output logic             m_axis_tlast,  // last
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [3:0] chan_q;
  logic [6:0] capf_q;

  logic [31:0]     slot_pid_q  [SourceSlots];
  logic [SourceSlots-1:0] slot_used_q;
  logic [PtrW-1:0] slot_head_q [SourceSlots];
  logic [CntW-1:0] slot_cnt_q  [SourceSlots];
  logic [31:0]     excl_pid_q  [ExcludeSlots];
  logic [ExcludeSlots-1:0] excl_used_q;
  logic [SourceSlots-1:0] contrib_q;

  logic [15:0] fifo_mem [SourceSlots*FifoSamples];
  logic [SumW-1:0] sum_mem [FifoSamples];

  state_e state_q;
  logic [2:0]  req_q;
  logic [31:0] pid_q;
  logic [15:0] smp_q;
  logic [SlotW-1:0] si_q;
  logic [ExclW-1:0] ei_q;
  logic [CntW-1:0]  k_q;
  logic found_q, free_ok_q, excl_hit_q;
  logic [SlotW-1:0] free_q, hit_q;
  logic [ExclW-1:0] efree_q;
  logic efree_ok_q;
  logic [1:0] stat_q;
  logic [6:0] n_q;
  logic [CntW-1:0] total_q;
  logic any_q;
  logic pass_q;
  logic [SumW-1:0] peak_q;
  logic [15:0] rd_q;
  logic [SumW-1:0] srd_q;
  logic [5:0] div_i_q;
  logic [34:0] rem_q;
  logic [33:0] num_q;
  logic [17:0] quo_q;
  logic neg_q;

  logic        ov_q;
  logic [1:0]  okind_q, ostat_q;
  logic [16:0] osmp_q;
  logic [6:0]  ofr_q;
  logic [5:0]  oidx_q;
  logic        olast_q;

  logic cfg_wr;
  logic [1:0] reg_idx;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign reg_idx = {1'b0, paddr[2]};
  always_comb begin
    prdata = '0;
    case (reg_idx)
      AddrChannels: prdata = {28'd0, chan_q};
      AddrCap:      prdata = {25'd0, capf_q};
      default:      prdata = '0;
    endcase
  end

  logic [3:0] c_eff;
  logic [10:0] cap_raw;
  logic [CntW-1:0] cap;
  assign c_eff   = (chan_q == 4'd0) ? 4'd1 : chan_q;
  assign cap_raw = capf_q * c_eff;
  assign cap     = (cap_raw > 11'(FifoSamples)) ? CntW'(FifoSamples) : CntW'(cap_raw);

  // per-slot frames held: count / channels over a small compare chain
  logic [6:0] have;
  always_comb begin
    have = '0;
    for (int f = 1; f <= 64; f++) begin
      if (11'(slot_cnt_q[si_q]) >= 11'(f) * 11'(c_eff)) have = 7'(f);
    end
  end

  logic excl_match;
  assign excl_match = excl_used_q[ei_q] && (excl_pid_q[ei_q] == pid_q);

  logic in_acc;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  logic out_free;
  assign out_free = !ov_q || m_axis_tready;

  logic [SlotW+PtrW-1:0] fifo_addr;
  always_comb begin
    fifo_addr = {si_q, PtrW'(slot_head_q[si_q] + k_q[PtrW-1:0])};
  end

  logic [SumW-1:0] abs_srd;
  assign abs_srd = srd_q[SumW-1] ? -srd_q : srd_q;

  logic [CntW:0]   push_inc;
  assign push_inc = {1'b0, slot_cnt_q[si_q]} + 1'b1;

  always_ff @(posedge clk_i) begin
    if (state_q == StPushWr && cap != '0) begin
      fifo_mem[{si_q, PtrW'(slot_head_q[si_q] + slot_cnt_q[si_q][PtrW-1:0])}] <= smp_q;
    end
    rd_q  <= fifo_mem[fifo_addr];
    srd_q <= sum_mem[k_q[PtrW-1:0]];
    if (state_q == StSumClr) sum_mem[k_q[PtrW-1:0]] <= '0;
    else if (state_q == StSumAcc) begin
      sum_mem[k_q[PtrW-1:0]] <= srd_q + SumW'(signed'(rd_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q      <= 4'd2;
      capf_q      <= 7'd32;
      state_q     <= StIdle;
      slot_used_q <= '0;
      excl_used_q <= '0;
      ov_q        <= 1'b0;
      for (int i = 0; i < SourceSlots; i++) begin
        slot_head_q[i] <= '0;
        slot_cnt_q[i]  <= '0;
      end
    end else begin
      if (cfg_wr) begin
        if (reg_idx == AddrChannels) chan_q <= pwdata[3:0];
        else if (reg_idx == AddrCap) capf_q <= pwdata[6:0];
      end
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      case (state_q)
        StIdle: if (in_acc) begin
          req_q <= s_axis_tuser;
          pid_q <= s_axis_tdata[31:0];
          smp_q <= s_axis_tdata[47:32];
          si_q <= '0; ei_q <= '0; k_q <= '0;
          found_q <= 1'b0; free_ok_q <= 1'b0; excl_hit_q <= 1'b0;
          efree_ok_q <= 1'b0; stat_q <= StatOk;
          any_q <= 1'b0; n_q <= '0; pass_q <= 1'b0; contrib_q <= '0;
          case (s_axis_tuser)
            ReqPush:    state_q <= StPush;
            ReqMix:     state_q <= StScan;
            ReqExclude: state_q <= StExcl;
            ReqClrExcl: begin excl_used_q <= '0; state_q <= StAck; end
            ReqClrAll: begin
              excl_used_q <= '0; slot_used_q <= '0;
              for (int i = 0; i < SourceSlots; i++) begin
                slot_head_q[i] <= '0;
                slot_cnt_q[i]  <= '0;
              end
              state_q <= StAck;
            end
            default:    state_q <= StAck;
          endcase
        end
        StPush: begin
          if (!found_q && slot_used_q[si_q] && slot_pid_q[si_q] == pid_q) begin
            found_q <= 1'b1; hit_q <= si_q;
          end
          if (!free_ok_q && !slot_used_q[si_q]) begin
            free_ok_q <= 1'b1; free_q <= si_q;
          end
          si_q <= si_q + 1'b1;
          if (si_q == SlotW'(SourceSlots-1)) begin
            if (found_q || (slot_used_q[si_q] && slot_pid_q[si_q] == pid_q)) begin
              si_q <= (found_q) ? hit_q : si_q;
              state_q <= StPushWr;
            end else if (free_ok_q || !slot_used_q[si_q]) begin
              si_q <= free_ok_q ? free_q : si_q;
              slot_used_q[free_ok_q ? free_q : si_q] <= 1'b1;
              slot_pid_q[free_ok_q ? free_q : si_q]  <= pid_q;
              slot_head_q[free_ok_q ? free_q : si_q] <= '0;
              slot_cnt_q[free_ok_q ? free_q : si_q]  <= '0;
              state_q <= StPushWr;
            end else begin
              stat_q <= StatFull; state_q <= StAck;
            end
          end
        end
        StPushWr: begin
          if (push_inc > {1'b0, cap}) begin
            stat_q <= StatDropped;
            slot_cnt_q[si_q]  <= cap;
            slot_head_q[si_q] <= PtrW'(slot_head_q[si_q] + (push_inc - {1'b0, cap}));
          end else begin
            slot_cnt_q[si_q] <= push_inc[CntW-1:0];
          end
          state_q <= StAck;
        end
        StExcl: begin
          if (excl_match) excl_hit_q <= 1'b1;
          if (!efree_ok_q && !excl_used_q[ei_q]) begin
            efree_ok_q <= 1'b1; efree_q <= ei_q;
          end
          ei_q <= ei_q + 1'b1;
          if (ei_q == ExclW'(ExcludeSlots-1)) begin
            state_q <= StAck;
            if (!(excl_hit_q || excl_match)) begin
              if (efree_ok_q || !excl_used_q[ei_q]) begin
                excl_used_q[efree_ok_q ? efree_q : ei_q] <= 1'b1;
                excl_pid_q[efree_ok_q ? efree_q : ei_q]  <= pid_q;
              end else stat_q <= StatFull;
            end
          end
        end
        StScan: begin
          // per slot: walk exclusion table comparing its pid, then judge
          pid_q <= slot_pid_q[si_q];
          if (ei_q == '0) excl_hit_q <= 1'b0;
          if (k_q == '0) begin
            k_q <= 1'b1;
          end else begin
            if (excl_match) excl_hit_q <= 1'b1;
            ei_q <= ei_q + 1'b1;
            if (ei_q == ExclW'(ExcludeSlots-1)) begin
              k_q <= '0; ei_q <= '0;
              if (slot_used_q[si_q] && !(excl_hit_q || excl_match)) begin
                if (!pass_q) begin
                  if (have != '0) begin
                    if (!any_q || have < n_q) n_q <= have;
                    any_q <= 1'b1;
                  end
                end else if (slot_cnt_q[si_q] >= total_q) contrib_q[si_q] <= 1'b1;
              end
              si_q <= si_q + 1'b1;
              if (si_q == SlotW'(SourceSlots-1)) begin
                if (!pass_q) begin
                  if (!any_q && !(slot_used_q[si_q] && !(excl_hit_q || excl_match)
                                  && have != '0)) begin
                    state_q <= StAck;
                  end else begin
                    pass_q <= 1'b1;
                  end
                end else begin
                  state_q <= StSumClr;
                end
              end
            end
          end
          if (pass_q == 1'b0 && si_q == SlotW'(SourceSlots-1) && k_q != '0 &&
              ei_q == ExclW'(ExcludeSlots-1)) begin
            // total computed from final n on next cycle
          end
        end
        StSumClr: begin
          k_q <= k_q + 1'b1;
          if (k_q + 1'b1 == total_q) begin
            k_q <= '0; si_q <= '0; state_q <= StSumRd;
          end
        end
        StSumRd: begin
          if (!contrib_q[si_q]) begin
            si_q <= si_q + 1'b1;
            if (si_q == SlotW'(SourceSlots-1)) begin
              k_q <= '0; peak_q <= '0; state_q <= StPeak; pass_q <= 1'b0;
            end
          end else state_q <= StSumAcc;
        end
        StSumAcc: begin
          k_q <= k_q + 1'b1;
          state_q <= StSumRd;
          if (k_q + 1'b1 == total_q) begin
            k_q <= '0;
            si_q <= si_q + 1'b1;
            if (si_q == SlotW'(SourceSlots-1)) begin
              peak_q <= '0; state_q <= StPeak; pass_q <= 1'b0;
            end
          end
        end
        StPeak: begin
          // pass_q low: read issued; high: data valid
          if (!pass_q) pass_q <= 1'b1;
          else begin
            pass_q <= 1'b0;
            if (abs_srd > peak_q) peak_q <= abs_srd;
            k_q <= k_q + 1'b1;
            if (k_q + 1'b1 == total_q) begin
              k_q <= '0; state_q <= StDiv; div_i_q <= '0;
            end
          end
        end
        StDiv: begin
          if (div_i_q == '0) begin
            div_i_q <= 6'd1;
          end else if (div_i_q == 6'd1) begin
            neg_q <= srd_q[SumW-1];
            num_q <= {abs_srd, 15'd0} + 34'(peak_q >> 1);
            rem_q <= '0; quo_q <= '0;
            if (peak_q > SumW'(OneQ15)) div_i_q <= 6'd2;
            else begin
              quo_q <= 18'(abs_srd); neg_q <= srd_q[SumW-1];
              state_q <= StEmit;
            end
          end else begin
            if ({rem_q[33:0], num_q[33]} >= 35'(peak_q)) begin
              rem_q <= {rem_q[33:0], num_q[33]} - 35'(peak_q);
              quo_q <= {quo_q[16:0], 1'b1};
            end else begin
              rem_q <= {rem_q[33:0], num_q[33]};
              quo_q <= {quo_q[16:0], 1'b0};
            end
            num_q <= {num_q[32:0], 1'b0};
            div_i_q <= div_i_q + 1'b1;
            if (div_i_q == 6'd35) state_q <= StEmit;
          end
        end
        StEmit: if (out_free) begin
          ov_q <= 1'b1; okind_q <= KindSample; ostat_q <= StatOk;
          osmp_q <= neg_q ? -quo_q[16:0] : quo_q[16:0];
          ofr_q <= n_q; oidx_q <= k_q[5:0];
          olast_q <= (k_q + 1'b1 == total_q);
          k_q <= k_q + 1'b1; div_i_q <= '0;
          if (k_q + 1'b1 == total_q) begin
            si_q <= '0; state_q <= StConsume;
          end else state_q <= StDiv;
        end
        StConsume: begin
          for (int i = 0; i < SourceSlots; i++) begin
            if (contrib_q[i]) begin
              slot_head_q[i] <= PtrW'(slot_head_q[i] + total_q);
              slot_cnt_q[i]  <= slot_cnt_q[i] - total_q;
            end
          end
          state_q <= StIdle;
        end
        StAck: if (out_free) begin
          ov_q <= 1'b1;
          okind_q <= (req_q == ReqMix) ? KindNone : KindAck;
          ostat_q <= stat_q; osmp_q <= '0; ofr_q <= '0; oidx_q <= '0;
          olast_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= CntW'(n_q * c_eff);
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'd0, oidx_q, ofr_q, osmp_q};
  assign m_axis_tuser  = {ostat_q, okind_q};
  assign m_axis_tlast  = olast_q;

  logic unused_tlast;
  assign unused_tlast = s_axis_tlast ^ (^pwdata[31:7]) ^ paddr[0] ^ paddr[1];

endmodule

`default_nettype wire

// ----- tb/multi_stream_audio_mixer_test.sv -----
// ----------------------------------------------------------------------------
// multi_stream_audio_mixer_test
// Drives push, mix, exclude, clear and unknown requests through the stream input,
// changes channel count and frame cap between phases over the register port,
// and checks every result against a cycle-free model of the source FIFOs,
// exclusion table and normalizing mixer.
// ----------------------------------------------------------------------------
module multi_stream_audio_mixer_test;
  import msam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [16:0] smp;
    logic [6:0]  frames;
    logic [5:0]  idx;
    logic        last;
  } mix_result_t;

  class mixer_scoreboard;
    mix_result_t pending[$];
    int          mismatches;
    logic [31:0] pid_of[SourceSlots];
    bit          used[SourceSlots];
    logic [15:0] fifo[SourceSlots][FifoSamples];
    int          head[SourceSlots];
    int          count[SourceSlots];
    logic [31:0] excl_pid[ExcludeSlots];
    bit          excl_used[ExcludeSlots];
    int          chan_reg;
    int          cap_reg;

    function new();
      chan_reg = 2;
      cap_reg  = 32;
    endfunction

    function void add(logic [1:0] k, logic [1:0] st, logic [16:0] s, logic [6:0] f,
                      logic [5:0] i, logic l);
      mix_result_t r;
      r.kind = k; r.status = st; r.smp = s; r.frames = f; r.idx = i; r.last = l;
      pending.push_back(r);
    endfunction

    function bit excluded(logic [31:0] pid);
      for (int i = 0; i < ExcludeSlots; i++)
        if (excl_used[i] && excl_pid[i] == pid) return 1;
      return 0;
    endfunction

    function int chans();
      return chan_reg == 0 ? 1 : chan_reg;
    endfunction

    function logic [1:0] push_sample(logic [31:0] pid, logic [15:0] s);
      int sl, cap;
      logic [1:0] st;
      sl = -1;
      st = StatOk;
      for (int i = 0; i < SourceSlots; i++)
        if (sl < 0 && used[i] && pid_of[i] == pid) sl = i;
      if (sl < 0) begin
        for (int i = 0; i < SourceSlots; i++)
          if (sl < 0 && !used[i]) sl = i;
        if (sl < 0) return StatFull;
        used[sl] = 1; pid_of[sl] = pid; head[sl] = 0; count[sl] = 0;
      end
      cap = cap_reg * chans();
      if (cap > FifoSamples) cap = FifoSamples;
      fifo[sl][(head[sl] + count[sl]) % FifoSamples] = s;
      count[sl]++;
      while (count[sl] > cap) begin
        head[sl] = (head[sl] + 1) % FifoSamples;
        count[sl]--;
        st = StatDropped;
      end
      return st;
    endfunction

    function logic [1:0] exclude_pid(logic [31:0] pid);
      if (excluded(pid)) return StatOk;
      for (int i = 0; i < ExcludeSlots; i++)
        if (!excl_used[i]) begin
          excl_used[i] = 1;
          excl_pid[i] = pid;
          return StatOk;
        end
      return StatFull;
    endfunction

    function void mix();
      int c, n, total;
      bit any;
      bit part[SourceSlots];
      longint sums[FifoSamples];
      longint peak, a, q, v;
      c = chans();
      n = 0;
      any = 0;
      for (int i = 0; i < SourceSlots; i++) begin
        part[i] = used[i] && !excluded(pid_of[i]);
        if (part[i] && count[i] / c > 0) begin
          if (!any || count[i] / c < n) n = count[i] / c;
          any = 1;
        end
      end
      if (!any) begin
        add(KindNone, StatOk, '0, '0, '0, 1'b1);
        return;
      end
      total = n * c;
      for (int k = 0; k < total; k++) sums[k] = 0;
      for (int i = 0; i < SourceSlots; i++) begin
        part[i] = part[i] && count[i] >= total;
        if (part[i])
          for (int k = 0; k < total; k++)
            sums[k] += longint'($signed(fifo[i][(head[i] + k) % FifoSamples]));
      end
      peak = 0;
      for (int k = 0; k < total; k++) begin
        a = sums[k] < 0 ? -sums[k] : sums[k];
        if (a > peak) peak = a;
      end
      for (int k = 0; k < total; k++) begin
        v = sums[k];
        if (peak > OneQ15) begin
          a = v < 0 ? -v : v;
          q = (a * OneQ15 + peak / 2) / peak;
          v = v < 0 ? -q : q;
        end
        add(KindSample, StatOk, v[16:0], n[6:0], k[5:0], k + 1 == total);
      end
      for (int i = 0; i < SourceSlots; i++)
        if (part[i]) begin
          head[i] = (head[i] + total) % FifoSamples;
          count[i] -= total;
        end
    endfunction

    function void note_request(logic [2:0] req, logic [31:0] pid, logic [15:0] s);
      logic [1:0] st;
      st = StatOk;
      case (req)
        ReqPush: st = push_sample(pid, s);
        ReqMix: begin
          mix();
          return;
        end
        ReqExclude: st = exclude_pid(pid);
        ReqClrExcl: for (int i = 0; i < ExcludeSlots; i++) excl_used[i] = 0;
        ReqClrAll: begin
          for (int i = 0; i < ExcludeSlots; i++) excl_used[i] = 0;
          for (int i = 0; i < SourceSlots; i++) begin
            used[i] = 0; head[i] = 0; count[i] = 0;
          end
        end
        default: ;
      endcase
      add(KindAck, st, '0, '0, '0, 1'b1);
    endfunction

    function void check_result(logic [31:0] data, logic [3:0] user, logic lst);
      mix_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result tdata=%h tuser=%h", data, user);
        return;
      end
      e = pending.pop_front();
      if (user[1:0] !== e.kind || user[3:2] !== e.status || data[16:0] !== e.smp ||
          data[23:17] !== e.frames || data[29:24] !== e.idx || data[31:30] !== 2'b00 ||
          lst !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp kind %0d st %0d smp %h n %0d idx %0d last %0d,",
                   e.kind, e.status, e.smp, e.frames, e.idx, e.last,
                   " got kind %0d st %0d smp %h n %0d idx %0d last %0d",
                   user[1:0], user[3:2], data[16:0], data[23:17], data[29:24], lst);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // process_id, sample
  logic [2:0]  s_axis_tuser = '0;   // req_type
  logic        s_axis_tlast = 1'b0; // push_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // mixed_sample, frames_mixed, sample_index
  logic [3:0]  m_axis_tuser;        // result_kind, status
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mixer_scoreboard sb = new();
  bit          steady = 1'b0;
  longint      cycles = 0;
  logic [31:0] pid_pool[10];

  multi_stream_audio_mixer uut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 10000000) begin
      $display("multi_stream_audio_mixer_test: errors");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);

  // receiver with one long hold-off
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (cycles == 4000) hold = 600;
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || $urandom_range(99) >= 30;
      end
    end
  end

  task automatic send(logic [2:0] req, logic [31:0] pid, logic [15:0] smp, logic lst);
    if (!steady && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {smp, pid};
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(req, pid, smp);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index[0], 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == AddrChannels) sb.chan_reg = value[3:0];
    else sb.cap_reg = value[6:0];
  endtask

  task automatic random_phase(int items, int pids);
    int r;
    logic [15:0] smp;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      smp = $urandom_range(3) == 0 ? ($urandom_range(1) ? 16'h7fff : 16'h8000)
                                   : 16'($urandom);
      if (r < 70)
        send(ReqPush, pid_pool[$urandom_range(pids - 1)], smp, 1'($urandom_range(1)));
      else if (r < 86) send(ReqMix, $urandom, 16'($urandom), 1'($urandom_range(1)));
      else if (r < 92)
        send(ReqExclude, pid_pool[$urandom_range(pids - 1)], 16'($urandom), 1'b0);
      else if (r < 94) send(ReqClrExcl, $urandom, 16'($urandom), 1'b0);
      else if (r < 96) send(ReqClrAll, $urandom, 16'($urandom), 1'b0);
      else if (r < 98) send(3'($urandom_range(5, 7)), $urandom, 16'($urandom), 1'b1);
      else send(ReqPush, $urandom, smp, 1'b1);
    end
  endtask

  initial begin
    for (int i = 0; i < 10; i++) pid_pool[i] = $urandom;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send(ReqPush, 32'h0, 16'h8000, 1'b0);
    send(ReqPush, 32'h0, 16'h8000, 1'b1);
    send(ReqPush, 32'hffffffff, 16'h7fff, 1'b0);
    send(ReqPush, 32'hffffffff, 16'h7fff, 1'b0);
    send(ReqPush, 32'hffffffff, 16'h7fff, 1'b1);
    send(ReqMix, '0, '0, 1'b0);
    send(ReqMix, '0, '0, 1'b0);
    send(ReqPush, 32'hffffffff, 16'h8000, 1'b1);
    send(ReqExclude, 32'hffffffff, '0, 1'b0);
    send(ReqExclude, 32'hffffffff, '0, 1'b0);
    send(ReqMix, '0, '0, 1'b0);
    send(ReqClrExcl, '0, '0, 1'b0);
    for (int i = 0; i < 9; i++) send(ReqPush, pid_pool[i], 16'h4000, 1'b1);
    for (int i = 0; i < 9; i++) send(ReqExclude, pid_pool[i], '0, 1'b0);
    send(3'd5, '0, '0, 1'b0);
    send(3'd7, '1, '1, 1'b1);
    send(ReqClrAll, '0, '0, 1'b0);
    send(ReqMix, '0, '0, 1'b0);
    drain();

    write_reg(AddrChannels, 1);
    write_reg(AddrCap, 64);
    random_phase(60, 6);
    drain();
    write_reg(AddrChannels, 8);
    write_reg(AddrCap, 1);
    steady = 1'b1;
    random_phase(40, 5);
    steady = 1'b0;
    drain();
    write_reg(AddrChannels, 3);
    write_reg(AddrCap, 5);
    random_phase(60, 10);
    drain();
    write_reg(AddrCap, 0);
    write_reg(AddrChannels, 0);
    random_phase(20, 4);
    drain();
    write_reg(AddrChannels, 15);
    write_reg(AddrCap, 127);
    random_phase(40, 4);
    drain();
    write_reg(AddrChannels, 2);
    write_reg(AddrCap, 32);
    random_phase(40, 7);
    drain();

    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("multi_stream_audio_mixer_test: clean");
    else
      $display("multi_stream_audio_mixer_test: errors");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/msam_pkg.sv
hw/rtl/multi_stream_audio_mixer.sv
tb/multi_stream_audio_mixer_test.sv
